>>> rtl/rrvw_pkg.sv
// shared types and constants for the round-robin vertex worklist
// no dependencies; imported by the controller, the datapath and the top level
package rrvw_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int VTX_W        = 6;
    localparam int SIZE_W       = 7;

    typedef enum logic [1:0] {
        REQ_NEXT     = 2'd0,
        REQ_MARK_CMP = 2'd1,
        REQ_MARK_LST = 2'd2,
        REQ_SEEK     = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_POS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SINGLE,
        S_NEXT_EV,
        S_CMP_RD,
        S_CMP_EV,
        S_LST_RD,
        S_LST_EV
    } state_t;

    // where the output beat takes its vertex from
    typedef enum logic [1:0] {
        OUT_PEND_LAST,
        OUT_PEND_MORE,
        OUT_READ
    } out_src_t;

    typedef struct packed {
        logic     rd_pos;
        logic     rd_walk;
        logic     map_wr;
        logic     seek_wr;
        logic     walk_init;
        logic     walk_inc;
        logic     cmp_step;
        logic     cmp_done;
        logic     map_clr;
        logic     pos_adv;
        logic     pend_load;
        status_t  pend_status;
        logic     list_take;
        logic     out_load;
        out_src_t out_src;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic size_zero;
        logic seek_bad;
        logic walk_end;
        logic rd_marked;
        logic pend_valid;
    } stat_t;

endpackage

>>> rtl/round_robin_vertex_worklist.sv
// top level of the round-robin vertex worklist
// depends on rrvw_pkg, rrvw_ctrl and rrvw_datapath
//
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tuser req_type, tlast mark_last,
//                                      tdata vertex_index, visited_bit, seek_position
// m_axis    out  tvalid/tready         tuser vertex_valid, status, tlast last_result,
//                                      tdata vertex, set_size, set_empty
// cfg       in   cfg_we                cfg_wdata vertex_count
//
// a non-final mark beat returns to idle; seek and next wait while the output is full
// final compaction and listing marks walk the stored vertices, reading then evaluating
// each, paced by the single read port of the vertex store; listing also waits on output stalls
// reset and a count write rebuild the store at once through per-entry valid bits
// a full output register holds the listing walk; input is taken only between requests
module round_robin_vertex_worklist (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [rrvw_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,  // vertex_index, visited_bit, seek_position
    input  logic [1:0]                  s_axis_tuser,  // req_type
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata,  // vertex, set_size, set_empty
    output logic [2:0]                  m_axis_tuser,  // vertex_valid, status
    output logic                        m_axis_tlast
);
    import rrvw_pkg::*;

    cmd_t              cmd;
    stat_t             stat;
    logic [VTX_W-1:0]  out_vertex;
    logic              out_vertex_valid;
    logic [SIZE_W-1:0] out_set_size;
    logic              out_set_empty;
    logic [1:0]        out_status;

    rrvw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_req   (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .stat     (stat),
        .cmd      (cmd)
    );

    rrvw_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .in_vertex_index  (s_axis_tdata[5:0]),
        .in_visited_bit   (s_axis_tdata[6]),
        .in_seek_position (s_axis_tdata[12:7]),
        .cmd              (cmd),
        .stat             (stat),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .out_vertex       (out_vertex),
        .out_vertex_valid (out_vertex_valid),
        .out_last         (m_axis_tlast),
        .out_set_size     (out_set_size),
        .out_set_empty    (out_set_empty),
        .out_status       (out_status)
    );

    assign m_axis_tdata = {2'b00, out_set_empty, out_set_size, out_vertex};
    assign m_axis_tuser = {out_status, out_vertex_valid};

endmodule

>>> rtl/rrvw_ctrl.sv
// sequencer for the vertex worklist: decodes requests and steps the walks
// depends on rrvw_pkg; drives the datapath through cmd_t, watches stat_t
module rrvw_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [1:0]     in_req,
    input  logic           in_last,
    input  rrvw_pkg::stat_t stat,
    output rrvw_pkg::cmd_t  cmd
);
    import rrvw_pkg::*;

    state_t state_reg;
    state_t state_next;
    req_t   req;
    logic   accept;
    logic   list_stall;

    assign req        = req_t'(in_req);
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign list_stall = stat.rd_marked && stat.pend_valid && !stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req)
                        REQ_NEXT:     state_next = stat.size_zero ? S_SINGLE : S_NEXT_EV;
                        REQ_SEEK:     state_next = S_SINGLE;
                        REQ_MARK_CMP: state_next = in_last ? S_CMP_RD : S_IDLE;
                        REQ_MARK_LST: state_next = in_last ? S_LST_RD : S_IDLE;
                    endcase
                end
            end
            S_SINGLE:  state_next = stat.out_free ? S_IDLE : S_SINGLE;
            S_NEXT_EV: state_next = stat.out_free ? S_IDLE : S_NEXT_EV;
            S_CMP_RD:  state_next = stat.walk_end ? S_SINGLE : S_CMP_EV;
            S_CMP_EV:  state_next = S_CMP_RD;
            S_LST_RD:  state_next = stat.walk_end ? S_SINGLE : S_LST_EV;
            S_LST_EV:  state_next = list_stall ? S_LST_EV : S_LST_RD;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.pend_status = ST_OK;
        cmd.out_src     = OUT_PEND_LAST;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req)
                        REQ_NEXT:
                        begin
                            if (stat.size_zero)
                            begin
                                cmd.pend_load   = 1'b1;
                                cmd.pend_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_pos = 1'b1;
                            end
                        end
                        REQ_SEEK:
                        begin
                            cmd.pend_load   = 1'b1;
                            cmd.pend_status = stat.seek_bad ? ST_BAD_POS : ST_OK;
                            cmd.seek_wr     = !stat.seek_bad;
                        end
                        REQ_MARK_CMP, REQ_MARK_LST:
                        begin
                            cmd.map_wr    = 1'b1;
                            cmd.walk_init = in_last;
                        end
                    endcase
                end
            end
            S_SINGLE:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_src  = OUT_PEND_LAST;
            end
            S_NEXT_EV:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_src  = OUT_READ;
                cmd.pos_adv  = stat.out_free;
            end
            S_CMP_RD:
            begin
                if (stat.walk_end)
                begin
                    cmd.cmp_done  = 1'b1;
                    cmd.map_clr   = 1'b1;
                    cmd.pend_load = 1'b1;
                end
                else
                begin
                    cmd.rd_walk = 1'b1;
                end
            end
            S_CMP_EV:
            begin
                cmd.cmp_step = 1'b1;
                cmd.walk_inc = 1'b1;
            end
            S_LST_RD:
            begin
                // pending slot already holds the final beat, or nothing
                cmd.map_clr = stat.walk_end;
                cmd.rd_walk = !stat.walk_end;
            end
            S_LST_EV:
            begin
                if (!list_stall)
                begin
                    cmd.walk_inc  = 1'b1;
                    cmd.list_take = stat.rd_marked;
                    cmd.out_load  = stat.rd_marked && stat.pend_valid;
                    cmd.out_src   = OUT_PEND_MORE;
                end
            end
            default:
            begin
                cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/rrvw_datapath.sv
// datapath of the vertex worklist: vertex store, visited bitmap, position,
// size, walk counters and the output register; depends on rrvw_pkg
module rrvw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rrvw_pkg::SIZE_W-1:0]   cfg_wdata,
    input  logic [rrvw_pkg::VTX_W-1:0]    in_vertex_index,
    input  logic                          in_visited_bit,
    input  logic [rrvw_pkg::VTX_W-1:0]    in_seek_position,
    input  rrvw_pkg::cmd_t                cmd,
    output rrvw_pkg::stat_t               stat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [rrvw_pkg::VTX_W-1:0]    out_vertex,
    output logic                          out_vertex_valid,
    output logic                          out_last,
    output logic [rrvw_pkg::SIZE_W-1:0]   out_set_size,
    output logic                          out_set_empty,
    output logic [1:0]                    out_status
);
    import rrvw_pkg::*;

    logic [VTX_W-1:0]        store_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] store_ok_reg;
    logic [MAX_VERTICES-1:0] visited_reg;

    logic [VTX_W-1:0]  rd_data_reg;
    logic              rd_ok_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic [VTX_W-1:0]  rd_word;

    logic [IDX_W-1:0]  pos_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] walk_j_reg;
    logic [SIZE_W-1:0] walk_k_reg;

    logic [VTX_W-1:0]  pend_vertex_reg;
    logic              pend_valid_reg;
    status_t           pend_status_reg;

    logic              out_valid_reg;
    logic [VTX_W-1:0]  out_vertex_reg;
    logic              out_vvalid_reg;
    logic              out_last_reg;
    logic [SIZE_W-1:0] out_size_reg;
    logic              out_empty_reg;
    status_t           out_status_reg;

    logic [IDX_W-1:0]  pos_eff;
    logic [IDX_W-1:0]  rd_addr;
    logic              rd_en;
    logic [SIZE_W-1:0] pos_inc;
    logic [SIZE_W-1:0] cfg_count;
    logic              store_we;
    logic              out_free;

    // an entry never written since the last rebuild still holds its own index
    assign rd_word  = rd_ok_reg ? rd_data_reg : VTX_W'(rd_addr_reg);
    assign pos_eff  = (SIZE_W'(pos_reg) < size_reg) ? pos_reg : '0;
    assign rd_addr  = cmd.rd_walk ? walk_j_reg[IDX_W-1:0] : pos_eff;
    assign rd_en    = cmd.rd_pos || cmd.rd_walk;
    assign pos_inc  = SIZE_W'(rd_addr_reg) + SIZE_W'(1);
    assign store_we = cmd.cmp_step && !stat.rd_marked;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        priority if (cfg_wdata == '0)
            cfg_count = SIZE_W'(1);
        else if (cfg_wdata > SIZE_W'(MAX_VERTICES))
            cfg_count = SIZE_W'(MAX_VERTICES);
        else
            cfg_count = cfg_wdata;
    end

    assign stat.out_free   = out_free;
    assign stat.size_zero  = (size_reg == '0);
    assign stat.seek_bad   = (SIZE_W'(in_seek_position) >= size_reg);
    assign stat.walk_end   = (walk_j_reg == size_reg);
    assign stat.rd_marked  = visited_reg[rd_word[IDX_W-1:0]];
    assign stat.pend_valid = pend_valid_reg;

    // vertex store and its read port
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[walk_k_reg[IDX_W-1:0]] <= rd_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
            rd_ok_reg   <= store_ok_reg[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_ok_reg <= '0;
            visited_reg  <= '0;
            pos_reg      <= '0;
            size_reg     <= SIZE_W'(MAX_VERTICES);
            walk_j_reg   <= '0;
            walk_k_reg   <= '0;
        end
        else if (cfg_we)
        begin
            store_ok_reg <= '0;
            visited_reg  <= '0;
            pos_reg      <= '0;
            size_reg     <= cfg_count;
        end
        else
        begin
            if (store_we)
            begin
                store_ok_reg[walk_k_reg[IDX_W-1:0]] <= 1'b1;
                walk_k_reg <= walk_k_reg + SIZE_W'(1);
            end
            if (cmd.map_clr)
            begin
                visited_reg <= '0;
            end
            else if (cmd.map_wr && (SIZE_W'(in_vertex_index) < SIZE_W'(MAX_VERTICES)))
            begin
                visited_reg[in_vertex_index[IDX_W-1:0]] <= in_visited_bit;
            end
            if (cmd.walk_init)
            begin
                walk_j_reg <= '0;
                walk_k_reg <= '0;
            end
            else if (cmd.walk_inc)
            begin
                walk_j_reg <= walk_j_reg + SIZE_W'(1);
            end
            if (cmd.cmp_done)
            begin
                size_reg <= walk_k_reg;
                pos_reg  <= '0;
            end
            else if (cmd.seek_wr)
            begin
                pos_reg <= in_seek_position[IDX_W-1:0];
            end
            else if (cmd.pos_adv)
            begin
                pos_reg <= (pos_inc >= size_reg) ? '0 : pos_inc[IDX_W-1:0];
            end
        end
    end

    // one listed vertex is held back so the final beat can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.walk_init || cmd.pend_load)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.list_take)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_init || cmd.pend_load)
        begin
            pend_vertex_reg <= '0;
            pend_status_reg <= cmd.walk_init ? ST_OK : cmd.pend_status;
        end
        else if (cmd.list_take)
        begin
            pend_vertex_reg <= rd_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_size_reg  <= size_reg;
            out_empty_reg <= (size_reg == '0);
            unique case (cmd.out_src)
                OUT_READ:
                begin
                    out_vertex_reg <= rd_word;
                    out_vvalid_reg <= 1'b1;
                    out_last_reg   <= 1'b1;
                    out_status_reg <= ST_OK;
                end
                OUT_PEND_MORE:
                begin
                    out_vertex_reg <= pend_vertex_reg;
                    out_vvalid_reg <= pend_valid_reg;
                    out_last_reg   <= 1'b0;
                    out_status_reg <= ST_OK;
                end
                default:
                begin
                    out_vertex_reg <= pend_vertex_reg;
                    out_vvalid_reg <= pend_valid_reg;
                    out_last_reg   <= 1'b1;
                    out_status_reg <= pend_status_reg;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_vertex       = out_vertex_reg;
    assign out_vertex_valid = out_vvalid_reg;
    assign out_last         = out_last_reg;
    assign out_set_size     = out_size_reg;
    assign out_set_empty    = out_empty_reg;
    assign out_status       = out_status_reg;

endmodule

>>> dv/rrvw_checker.sv
// checker for the round-robin vertex worklist: predicts every result beat and compares it
// depends on rrvw_pkg; watches the request, result and count-write ports of the block
module rrvw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // vertex_index, visited_bit, seek_position
    input  logic [1:0]  s_axis_tuser,   // req_type
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // vertex, set_size, set_empty
    input  logic [2:0]  m_axis_tuser,   // vertex_valid, status
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          awaited,
    output int          beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rrvw_pkg::*;

    typedef struct packed {
        logic [VTX_W-1:0]  vertex;
        logic              vertex_valid;
        logic              last_result;
        logic [SIZE_W-1:0] set_size;
        logic              set_empty;
        status_t           status;
    } wl_beat_t;

    logic [VTX_W-1:0] order_q [MAX_VERTICES];
    bit               seen [MAX_VERTICES];
    int unsigned      rd_pos;
    int unsigned      set_sz;
    int unsigned      vcount;
    wl_beat_t         due_beats [$];

    function automatic void rebuild_set();
        for (int k = 0; k < MAX_VERTICES; k++)
        begin
            order_q[k] = VTX_W'(k);
            seen[k]    = 1'b0;
        end
        rd_pos = 0;
        set_sz = vcount;
    endfunction

    function automatic void queue_result(logic [VTX_W-1:0] v, logic vv, logic lr, status_t st);
        wl_beat_t r;
        r.vertex       = v;
        r.vertex_valid = vv;
        r.last_result  = lr;
        r.set_size     = SIZE_W'(set_sz);
        r.set_empty    = (set_sz == 0);
        r.status       = st;
        due_beats.push_back(r);
    endfunction

    function automatic void apply_request(req_t rq, logic [5:0] vi, logic vb, logic ml,
                                          logic [5:0] sp);
        int unsigned      p;
        int unsigned      keep;
        int unsigned      hits;
        logic [VTX_W-1:0] v;
        wl_beat_t         tail;
        case (rq)
            REQ_NEXT:
            begin
                if (set_sz == 0)
                    queue_result('0, 1'b0, 1'b1, ST_EMPTY);
                else
                begin
                    // a stray position reads entry 0
                    p = (rd_pos < set_sz) ? rd_pos : 0;
                    v = order_q[p];
                    p++;
                    rd_pos = (p >= set_sz) ? 0 : p;
                    queue_result(v, 1'b1, 1'b1, ST_OK);
                end
            end
            REQ_SEEK:
            begin
                if (32'(sp) >= set_sz)
                    queue_result('0, 1'b0, 1'b1, ST_BAD_POS);
                else
                begin
                    rd_pos = 32'(sp);
                    queue_result('0, 1'b0, 1'b1, ST_OK);
                end
            end
            default:
            begin
                seen[vi] = vb;
                if (ml)
                begin
                    if (rq == REQ_MARK_CMP)
                    begin
                        keep = 0;
                        for (int j = 0; j < set_sz; j++)
                        begin
                            if (!seen[order_q[j]])
                            begin
                                order_q[keep] = order_q[j];
                                keep++;
                            end
                        end
                        set_sz = keep;
                        rd_pos = 0;
                        queue_result('0, 1'b0, 1'b1, ST_OK);
                    end
                    else
                    begin
                        hits = 0;
                        for (int j = 0; j < set_sz; j++)
                        begin
                            if (seen[order_q[j]])
                            begin
                                queue_result(order_q[j], 1'b1, 1'b0, ST_OK);
                                hits++;
                            end
                        end
                        if (hits == 0)
                            queue_result('0, 1'b0, 1'b1, ST_OK);
                        else
                        begin
                            tail = due_beats.pop_back();
                            tail.last_result = 1'b1;
                            due_beats.push_back(tail);
                        end
                    end
                    for (int k = 0; k < MAX_VERTICES; k++)
                        seen[k] = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_result_beat();
        wl_beat_t want;
        if (due_beats.size() == 0)
        begin
            $error("result beat with nothing expected: tdata %h tuser %h tlast %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
            fail_count++;
        end
        else
        begin
            want = due_beats.pop_front();
            beats_checked++;
            compare_field("vertex", 8'(want.vertex), 8'(m_axis_tdata[5:0]));
            compare_field("vertex_valid", 8'(want.vertex_valid), 8'(m_axis_tuser[0]));
            compare_field("last_result", 8'(want.last_result), 8'(m_axis_tlast));
            compare_field("set_size", 8'(want.set_size), 8'(m_axis_tdata[12:6]));
            compare_field("set_empty", 8'(want.set_empty), 8'(m_axis_tdata[13]));
            compare_field("status", 8'(want.status), 8'(m_axis_tuser[2:1]));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount = MAX_VERTICES;
            rebuild_set();
            due_beats.delete();
            fail_count    = 0;
            beats_checked = 0;
        end
        else
        begin
            // results first so a fresh request can never hide an unexpected beat
            if (m_axis_tvalid && m_axis_tready)
                check_result_beat();
            if (s_axis_tvalid && s_axis_tready)
                apply_request(req_t'(s_axis_tuser), s_axis_tdata[5:0], s_axis_tdata[6],
                              s_axis_tlast, s_axis_tdata[12:7]);
            if (cfg_we)
            begin
                if (cfg_wdata == 0)
                    vcount = 1;
                else if (cfg_wdata > MAX_VERTICES)
                    vcount = MAX_VERTICES;
                else
                    vcount = 32'(cfg_wdata);
                rebuild_set();
            end
        end
        awaited = due_beats.size();
    end

endmodule

>>> dv/tb_round_robin_vertex_worklist.sv
// stimulus and verdict for the round-robin vertex worklist
// depends on rrvw_pkg, the block's rtl and rrvw_checker, which does all the comparing
module tb_round_robin_vertex_worklist;
    timeunit 1ns;
    timeprecision 1ps;

    import rrvw_pkg::*;

    localparam int LONG_HOLD = 200;
    localparam int SETTLE    = 16;
    localparam int N_PHASES  = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic [6:0]  cfg_wdata     = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // vertex_index, visited_bit, seek_position
    logic [1:0]  s_axis_tuser  = '0;   // req_type
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // vertex, set_size, set_empty
    logic [2:0]  m_axis_tuser;         // vertex_valid, status
    logic        m_axis_tlast;

    int fail_count;
    int awaited;
    int beats_checked;

    bit tx_gaps     = 1'b1;
    bit rx_stalls   = 1'b1;
    bit rx_hold_req = 1'b0;
    int count_now   = MAX_VERTICES;
    int req_beats   = 0;
    int cfg_writes  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    round_robin_vertex_worklist uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rrvw_checker watch (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .awaited       (awaited),
        .beats_checked (beats_checked)
    );

    // result side: short random stalls, or one long hold-off on request
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                m_axis_tready <= 1'b0;
                for (int c = 1; c < LONG_HOLD; c++)
                    @(posedge clk);
                rx_hold_req = 1'b0;
            end
            else if (rx_stalls && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // valid stays high across back-to-back beats; it only drops for a gap or a drain
    task automatic send_req(req_t rq, logic [5:0] vi, logic vb, logic ml, logic [5:0] sp);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq;
        s_axis_tlast  <= ml;
        s_axis_tdata  <= {3'b000, sp, vb, vi};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        req_beats++;
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        // let the checker take in the last accepted beat first
        @(posedge clk);
        wait (awaited == 0);
        // a plain mark beat gives no result but may still be in flight
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_count(logic [6:0] v);
        drain_and_settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_now = (v == 0) ? 1 : ((v > MAX_VERTICES) ? MAX_VERTICES : v);
        cfg_writes++;
    endtask

    task automatic run_random(int n_items);
        int         sent;
        int         len;
        bit         cut;
        req_t       fin;
        req_t       rq;
        logic [5:0] pos;
        logic [5:0] vi;
        logic       vb;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                begin
                    send_req(REQ_NEXT, 6'($urandom), 1'($urandom), 1'($urandom), 6'($urandom));
                    sent++;
                end
                3:
                begin
                    pos = 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, count_now - 1));
                    send_req(REQ_SEEK, 6'($urandom), 1'($urandom), 1'($urandom), pos);
                    sent++;
                end
                9:
                begin
                    // stray mark, often without a last beat, leaves bits for the next run
                    send_req(req_t'($urandom_range(1, 2)), 6'($urandom), 1'($urandom),
                             ($urandom_range(0, 3) == 0), 6'($urandom));
                    sent++;
                end
                default:
                begin
                    fin = ($urandom_range(0, 4) < 3) ? REQ_MARK_LST : REQ_MARK_CMP;
                    len = $urandom_range(0, 6);
                    cut = ($urandom_range(0, 7) == 0);
                    for (int i = 0; i <= len; i++)
                    begin
                        if (cut && i == len / 2)
                        begin
                            send_req(REQ_NEXT, 6'($urandom), 1'($urandom), 1'($urandom),
                                     6'($urandom));
                            sent++;
                        end
                        rq = fin;
                        if (i != len && $urandom_range(0, 7) == 0)
                            rq = (fin == REQ_MARK_LST) ? REQ_MARK_CMP : REQ_MARK_LST;
                        vi = 6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                            : $urandom_range(0, count_now - 1));
                        vb = (fin == REQ_MARK_CMP) ? ($urandom_range(0, 2) == 0)
                                                   : 1'($urandom_range(0, 1));
                        send_req(rq, vi, vb, (i == len), 6'($urandom));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        int phase_cfg [N_PHASES];
        phase_cfg = '{0, 127, 2, 64, 9, 100, 17, 64};
        phase_cfg[4] = $urandom_range(3, 63);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full set after reset: wrap, listing, mixed mark types, compaction
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_SEEK, 6'd0, 1'b0, 1'b0, 6'd63);
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_MARK_LST, 6'd5, 1'b1, 1'b0, 6'd0);
        send_req(REQ_MARK_CMP, 6'd63, 1'b1, 1'b0, 6'd0);
        send_req(REQ_MARK_LST, 6'd5, 1'b0, 1'b0, 6'd0);
        send_req(REQ_MARK_LST, 6'd0, 1'b1, 1'b1, 6'd0);
        send_req(REQ_MARK_LST, 6'd10, 1'b0, 1'b1, 6'd0);
        send_req(REQ_MARK_CMP, 6'd63, 1'b1, 1'b0, 6'd0);
        send_req(REQ_MARK_CMP, 6'd0, 1'b1, 1'b1, 6'd0);
        send_req(REQ_SEEK, 6'd0, 1'b0, 1'b0, 6'd62);
        send_req(REQ_SEEK, 6'd0, 1'b0, 1'b0, 6'd61);
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_SEEK, 6'd0, 1'b0, 1'b0, 6'd5);
        // vertex 63 is gone, so only 6 gets listed and the position survives
        send_req(REQ_MARK_LST, 6'd63, 1'b1, 1'b0, 6'd0);
        send_req(REQ_MARK_LST, 6'd6, 1'b1, 1'b1, 6'd0);
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);

        // single vertex, then compacted down to an empty set
        write_count(7'd1);
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_MARK_CMP, 6'd0, 1'b1, 1'b1, 6'd0);
        send_req(REQ_NEXT, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_SEEK, 6'd0, 1'b0, 1'b0, 6'd0);
        send_req(REQ_MARK_LST, 6'd0, 1'b1, 1'b1, 6'd0);
        send_req(REQ_MARK_CMP, 6'd3, 1'b1, 1'b1, 6'd0);

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            write_count(7'(phase_cfg[ph]));
            if (ph == 3)
            begin
                // back up the output side until the block refuses requests
                rx_hold_req = 1'b1;
                repeat (12) send_req(REQ_NEXT, 6'($urandom), 1'($urandom), 1'($urandom),
                                     6'($urandom));
                drain_and_settle();
            end
            if (ph == N_PHASES - 1)
            begin
                tx_gaps   = 1'b0;
                rx_stalls = 1'b0;
            end
            run_random(56);
        end

        drain_and_settle();
        $display("covered %0d request beats, %0d result beats, %0d vertex-count writes",
                 req_beats, beats_checked, cfg_writes);
        $display("incl. empty set, bad seeks, mixed marks, listing, compaction, output hold-off");
        if (fail_count == 0 && awaited == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("run timed out with %0d results outstanding", awaited);
        $display("FAIL");
        $finish;
    end

endmodule

>>> round_robin_vertex_worklist.f
rtl/rrvw_pkg.sv
rtl/rrvw_ctrl.sv
rtl/rrvw_datapath.sv
rtl/round_robin_vertex_worklist.sv
dv/rrvw_checker.sv
dv/tb_round_robin_vertex_worklist.sv
